@@ design/tbb_pkg.sv @@
// ----------------------------------------------------------------------------
// tbb_pkg: shared types and constants for the transformed bounding box
// coordinate format, coefficient row layout, register map and lane control
// ----------------------------------------------------------------------------
package tbb_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int COEF_WIDTH  = 16;
    localparam int NUM_COEF    = 4;
    localparam int ROW_WIDTH   = COEF_WIDTH * NUM_COEF;
    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int NUM_LANES   = 3;

    localparam int PADDR_WIDTH = 5;
    localparam int REG_IDX_LSB = 3;
    localparam int PDATA_WIDTH = ROW_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COEF_WIDTH-1:0]  t_coef;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [ACC_WIDTH-1:0]   t_acc;
    typedef logic [ROW_WIDTH-1:0]          t_row;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_acc   ROUND_HALF = t_acc'((64'd1 << FRAC_BITS) >> 1);

    typedef enum logic [PADDR_WIDTH-REG_IDX_LSB-1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2
    } t_reg_idx;

    localparam t_row ROW_X_RESET = t_row'(64'd256);
    localparam t_row ROW_Y_RESET = t_row'(64'd16777216);
    localparam t_row ROW_Z_RESET = t_row'(64'd1099511627776);

    typedef struct packed {
        logic adv;
        logic s2_valid;
        logic s2_last;
    } t_lane_ctl;

    function automatic t_coef coef_of(t_row row, int k);
        coef_of = t_coef'(row[k*COEF_WIDTH +: COEF_WIDTH]);
    endfunction

    function automatic t_coord saturate(t_acc v);
        if (v > t_acc'(COORD_MAX)) begin
            saturate = COORD_MAX;
        end else if (v < t_acc'(COORD_MIN)) begin
            saturate = COORD_MIN;
        end else begin
            saturate = t_coord'(v);
        end
    endfunction

endpackage

@@ design/transformed_bounding_box.sv @@
// ----------------------------------------------------------------------------
// transformed_bounding_box: bounds of an affine-transformed vertex stream
// path: the item flagged last passes the product, coordinate and result registers before its bounds appear
// throughput: one vertex per cycle, one multiply-and-sum lane per axis
// the pipeline stalls only when a last item meets an untaken result
// reset: synchronous, identity matrix, trackers cleared, pipeline empty
// ----------------------------------------------------------------------------
module transformed_bounding_box (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tbb_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [tbb_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [tbb_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tbb_pkg::t_coord                     i_pos_x,
    input  tbb_pkg::t_coord                     i_pos_y,
    input  tbb_pkg::t_coord                     i_pos_z,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tbb_pkg::t_coord                     o_min_x,
    output tbb_pkg::t_coord                     o_min_y,
    output tbb_pkg::t_coord                     o_min_z,
    output tbb_pkg::t_coord                     o_max_x,
    output tbb_pkg::t_coord                     o_max_y,
    output tbb_pkg::t_coord                     o_max_z
);
    import tbb_pkg::*;

    t_row                   w_row [NUM_LANES];
    t_coord [NUM_LANES-1:0] w_low;
    t_coord [NUM_LANES-1:0] w_high;
    t_coord [NUM_LANES-1:0] w_out_low;
    t_coord [NUM_LANES-1:0] w_out_high;
    t_lane_ctl              w_ctl;
    logic                   w_full;
    logic                   w_adv;
    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic                   r_s2_valid;
    logic                   r_s2_last;

    tbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_row_x (w_row[0]),
        .o_row_y (w_row[1]),
        .o_row_z (w_row[2])
    );

    assign w_adv      = !(r_s2_valid && r_s2_last && w_full);
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_last <= i_last;
            r_s2_last <= r_s1_last;
        end
    end

    assign w_ctl.adv      = w_adv;
    assign w_ctl.s2_valid = r_s2_valid;
    assign w_ctl.s2_last  = r_s2_last;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        tbb_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_row   (w_row[g]),
            .i_x     (i_pos_x),
            .i_y     (i_pos_y),
            .i_z     (i_pos_z),
            .o_low   (w_low[g]),
            .o_high  (w_high[g])
        );
    end

    tbb_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_low       (w_low),
        .i_high      (w_high),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_full      (w_full),
        .o_low       (w_out_low),
        .o_high      (w_out_high)
    );

    assign o_min_x = w_out_low[0];
    assign o_min_y = w_out_low[1];
    assign o_min_z = w_out_low[2];
    assign o_max_x = w_out_high[0];
    assign o_max_y = w_out_high[1];
    assign o_max_z = w_out_high[2];

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s2_valid && r_s2_last && o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_s2_valid && r_s2_last))
        else $error("result appeared without a last item");

    a_bounds_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_min_x <= o_max_x && o_min_y <= o_max_y && o_min_z <= o_max_z))
        else $error("minimum above maximum in a result");

endmodule

@@ design/tbb_cfg.sv @@
// ----------------------------------------------------------------------------
// tbb_cfg: matrix row registers
// apb write and read access to the three affine rows
// ----------------------------------------------------------------------------
module tbb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tbb_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [tbb_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [tbb_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                pready,
    output tbb_pkg::t_row                       o_row_x,
    output tbb_pkg::t_row                       o_row_y,
    output tbb_pkg::t_row                       o_row_z
);
    import tbb_pkg::*;

    t_row     r_row_x;
    t_row     r_row_y;
    t_row     r_row_z;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_WIDTH-1:REG_IDX_LSB]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= ROW_X_RESET;
            r_row_y <= ROW_Y_RESET;
            r_row_z <= ROW_Z_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_ROW_X: r_row_x <= pwdata;
                REG_ROW_Y: r_row_y <= pwdata;
                REG_ROW_Z: r_row_z <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ROW_X: prdata = r_row_x;
            REG_ROW_Y: prdata = r_row_y;
            REG_ROW_Z: prdata = r_row_z;
            default:   prdata = '0;
        endcase
    end

    assign o_row_x = r_row_x;
    assign o_row_y = r_row_y;
    assign o_row_z = r_row_z;

endmodule

@@ design/tbb_lane.sv @@
// ----------------------------------------------------------------------------
// tbb_lane: one output axis
// multiply stage, sum round and saturate stage, running min and max tracker
// ----------------------------------------------------------------------------
module tbb_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbb_pkg::t_lane_ctl  i_ctl,
    input  tbb_pkg::t_row       i_row,
    input  tbb_pkg::t_coord     i_x,
    input  tbb_pkg::t_coord     i_y,
    input  tbb_pkg::t_coord     i_z,
    output tbb_pkg::t_coord     o_low,
    output tbb_pkg::t_coord     o_high
);
    import tbb_pkg::*;

    t_prod  r_p0;
    t_prod  r_p1;
    t_prod  r_p2;
    t_coord r_coord;
    t_coord r_low;
    t_coord r_high;
    t_acc   w_sum;
    t_acc   w_shift;
    t_coord w_low;
    t_coord w_high;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_p0 <= t_prod'(coef_of(i_row, 0)) * t_prod'(i_x);
            r_p1 <= t_prod'(coef_of(i_row, 1)) * t_prod'(i_y);
            r_p2 <= t_prod'(coef_of(i_row, 2)) * t_prod'(i_z);
        end
    end

    // stage 2: sum with translation, round-half-up shift, saturate
    assign w_sum = t_acc'(r_p0) + t_acc'(r_p1) + t_acc'(r_p2)
                 + (t_acc'(coef_of(i_row, 3)) <<< FRAC_BITS) + ROUND_HALF;
    assign w_shift = w_sum >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_coord <= saturate(w_shift);
        end
    end

    // tracker including the item in stage 2
    assign w_low  = (r_coord < r_low)  ? r_coord : r_low;
    assign w_high = (r_coord > r_high) ? r_coord : r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= COORD_MAX;
            r_high <= COORD_MIN;
        end else if (i_ctl.adv && i_ctl.s2_valid) begin
            if (i_ctl.s2_last) begin
                r_low  <= COORD_MAX;
                r_high <= COORD_MIN;
            end else begin
                r_low  <= w_low;
                r_high <= w_high;
            end
        end
    end

    assign o_low  = w_low;
    assign o_high = w_high;

endmodule

@@ design/tbb_merge.sv @@
// ----------------------------------------------------------------------------
// tbb_merge: result register
// gathers the bounds of all lanes into one output item
// ----------------------------------------------------------------------------
module tbb_merge (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  tbb_pkg::t_lane_ctl                          i_ctl,
    input  tbb_pkg::t_coord [tbb_pkg::NUM_LANES-1:0]    i_low,
    input  tbb_pkg::t_coord [tbb_pkg::NUM_LANES-1:0]    i_high,
    input  logic                                        i_out_ready,
    output logic                                        o_out_valid,
    output logic                                        o_full,
    output tbb_pkg::t_coord [tbb_pkg::NUM_LANES-1:0]    o_low,
    output tbb_pkg::t_coord [tbb_pkg::NUM_LANES-1:0]    o_high
);
    import tbb_pkg::*;

    logic                      r_valid;
    t_coord [NUM_LANES-1:0]    r_low;
    t_coord [NUM_LANES-1:0]    r_high;
    logic                      w_load;

    assign w_load = i_ctl.adv && i_ctl.s2_valid && i_ctl.s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_low  <= i_low;
            r_high <= i_high;
        end
    end

    assign o_out_valid = r_valid;
    assign o_full      = r_valid && !i_out_ready;
    assign o_low       = r_low;
    assign o_high      = r_high;

endmodule
